FILE: src/i2da_pkg.sv
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned STEP_W     = 34;
    localparam int unsigned CHAR_W     = 6;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    typedef logic [9:1][STEP_W-1:0]       step_row_t;
    typedef step_row_t [NUM_DIGITS-1:0]   step_tbl_t;

    // Multiples k * 10^p for every decimal position p and nonzero digit k.
    function automatic step_tbl_t build_steps();
        step_tbl_t         tbl;
        logic [STEP_W-1:0] p10;
        tbl = '0;
        p10 = 34'd1;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            for (int k = 1; k < 10; k++)
            begin
                tbl[i][k] = STEP_W'(p10 * STEP_W'(k));
            end
            p10 = STEP_W'(p10 * 34'd10);
        end
        return tbl;
    endfunction

    localparam step_tbl_t STEP_TBL = build_steps();

    typedef struct packed {
        logic load;
        logic setup;
        logic emit_sign;
        logic emit_digit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic neg;
        logic digit_last;
    } dp_status_t;

endpackage

FILE: src/int32_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// The input channel takes one two's complement value per beat. The output
// channel returns the text one character per beat, most significant first,
// with a leading minus sign for negative values and no leading zeros; the
// final character of each number carries last.
// A value is accepted only while the block is idle. In the setup state
// that follows acceptance the block finds the number of digits and, for a
// negative value, loads the minus sign once the output is free; after that
// one character is produced per cycle while the receiver takes them, each
// digit found by comparing the remaining magnitude against the nine
// multiples of the current power of ten. The minus sign is registered in
// the setup state; digits are registered in the digit state. The block
// takes no new number until the final digit of the current one has been
// registered. When the receiver stalls, the character register holds its
// beat and conversion pauses until that beat is taken.
// Reset clears the controller and the output valid; no state is kept
// from one number to the next.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [31:0]            value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [i2da_pkg::CHAR_W-1:0]   character,
    output logic                          last
);

    i2da_pkg::ctrl_cmd_t  cmd;
    i2da_pkg::dp_status_t status;

    i2da_controller u_controller
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    i2da_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .character (character),
        .last      (last)
    );

endmodule

FILE: src/i2da_datapath.sv
// ----------------------------------------------------------------------------
// i2da_datapath
// Magnitude register, digit position and the output character register.
// ----------------------------------------------------------------------------
module i2da_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [31:0]                  value,
    input  i2da_pkg::ctrl_cmd_t                 cmd,
    output i2da_pkg::dp_status_t                status,
    output logic [i2da_pkg::CHAR_W-1:0]         character,
    output logic                                last
);

    logic [31:0]                   mag_reg, mag_next;
    logic                          neg_reg, neg_next;
    logic [i2da_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [i2da_pkg::CHAR_W-1:0]   char_reg, char_next;
    logic                          last_reg, last_next;

    logic [i2da_pkg::POS_W-1:0]    start_pos;
    logic [3:0]                    digit;
    logic [i2da_pkg::STEP_W-1:0]   sub_val;
    logic [i2da_pkg::STEP_W-1:0]   mag_wide;
    i2da_pkg::step_row_t           row;

    assign mag_wide = {2'b00, mag_reg};
    assign row      = i2da_pkg::STEP_TBL[pos_reg];

    always_comb
    begin
        start_pos = '0;
        for (int p = 1; p < i2da_pkg::NUM_DIGITS; p++)
        begin
            if (mag_wide >= i2da_pkg::STEP_TBL[p][1])
            begin
                start_pos = i2da_pkg::POS_W'(p);
            end
        end
    end

    always_comb
    begin
        digit   = '0;
        sub_val = '0;
        for (int k = 1; k < 10; k++)
        begin
            if (mag_wide >= row[k])
            begin
                digit   = 4'(k);
                sub_val = row[k];
            end
        end
    end

    always_comb
    begin
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        pos_next  = pos_reg;
        char_next = char_reg;
        last_next = last_reg;
        if (cmd.load)
        begin
            neg_next = value[31];
            mag_next = value[31] ? (~value + 32'd1) : value;
        end
        if (cmd.setup)
        begin
            pos_next = start_pos;
        end
        if (cmd.emit_sign)
        begin
            char_next = i2da_pkg::CHAR_MINUS;
            last_next = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            char_next = i2da_pkg::CHAR_ZERO + {2'b00, digit};
            last_next = (pos_reg == '0);
            mag_next  = 32'(mag_wide - sub_val);
            pos_next  = pos_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg <= 1'b0;
            pos_reg <= '0;
        end
        else
        begin
            neg_reg <= neg_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.neg        = neg_reg;
    assign status.digit_last = (pos_reg == '0);
    assign character         = char_reg;
    assign last              = last_reg;

endmodule

FILE: src/i2da_controller.sv
// ----------------------------------------------------------------------------
// i2da_controller
// Sequences load, setup and character emission, and owns the output valid.
// ----------------------------------------------------------------------------
module i2da_controller
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  i2da_pkg::dp_status_t  status,
    output i2da_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIGITS
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (!status.neg || out_free)
                begin
                    cmd.setup     = 1'b1;
                    cmd.emit_sign = status.neg;
                    state_next    = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.digit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || cmd.emit_sign || cmd.emit_digit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("block accepted a value while still converting");

    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid_reg || out_ready))
        else $error("character written over an untaken beat");

    a_last_digit_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_digit && status.digit_last) |=> (in_ready && out_valid))
        else $error("final digit did not return the block to idle");

    a_one_emit_per_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_sign && cmd.emit_digit) && !(cmd.load && cmd.emit_digit))
        else $error("conflicting datapath commands");

endmodule

FILE: test/int32_to_decimal_ascii_test.sv
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_test
// Self-checking testbench for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
// Numbers are offered one beat at a time on the input channel. For every
// accepted number the expected characters, sign first and digits most
// significant first with last on the final one, are queued. The directed
// rows either carry their text typed in or take it from the decimal
// predictor. Each character beat on the output channel is compared with the
// oldest queued character. A random part follows, run under several idling
// patterns on both channels and one long receiver hold-off that backs up
// the input.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [i2da_pkg::CHAR_W-1:0] code;
        logic                        last;
    } text_char_t;

    typedef struct packed {
        logic [31:0] number;
        logic        typed;
        logic [87:0] text;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [31:0]          value;
    logic                        out_valid;
    logic                        out_ready;
    logic [i2da_pkg::CHAR_W-1:0] character;
    logic                        last;

    text_char_t pending_text [$];
    stim_row_t  directed_rows [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_off_request;
    bit hold_off_done;
    int mismatches;
    int unexpected_beats;
    int numbers_sent;
    int negatives_sent;
    int chars_checked;

    int32_to_decimal_ascii DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] power_of_ten(input int exponent);
        logic [31:0] p;
        p = 32'd1;
        for (int i = 0; i < exponent; i++)
        begin
            p = p * 32'd10;
        end
        return p;
    endfunction

    function automatic void push_decimal_text(input logic [31:0] word);
        logic        negative;
        logic [31:0] magnitude;
        logic [3:0]  digits [10];
        int          count;
        negative  = word[31];
        magnitude = negative ? (~word + 32'd1) : word;
        digits[0] = 4'(magnitude % 32'd10);
        magnitude = magnitude / 32'd10;
        count     = 1;
        while (magnitude != 32'd0 && count < 10)
        begin
            digits[count] = 4'(magnitude % 32'd10);
            magnitude     = magnitude / 32'd10;
            count++;
        end
        if (negative)
        begin
            pending_text.push_back('{i2da_pkg::CHAR_MINUS, 1'b0});
        end
        for (int k = count - 1; k >= 0; k--)
        begin
            pending_text.push_back('{i2da_pkg::CHAR_ZERO + i2da_pkg::CHAR_W'(digits[k]),
                                     k == 0});
        end
    endfunction

    function automatic void push_typed_text(input logic [87:0] text);
        logic [7:0] code;
        for (int i = 10; i >= 0; i--)
        begin
            code = text[i*8 +: 8];
            if (code != 8'd0)
            begin
                pending_text.push_back('{code[i2da_pkg::CHAR_W-1:0], i == 0});
            end
        end
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        int          pick;
        pick = $urandom_range(5);
        case (pick)
            0, 1:    v = $urandom;
            2:       v = $urandom_range(2000) - 1000;
            3:       v = power_of_ten($urandom_range(9)) + $urandom_range(2) - 1;
            4:       v = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                          : 32'h8000_0000 + $urandom_range(3);
            default: v = $urandom % power_of_ten($urandom_range(9, 1));
        endcase
        if (pick != 4 && pick >= 3 && $urandom_range(1))
        begin
            v = ~v + 32'd1;
        end
        return v;
    endfunction

    function automatic void add_row(input logic [31:0] number, input logic typed,
                                    input logic [87:0] text);
        directed_rows.push_back('{number, typed, text});
    endfunction

    task automatic offer_number(input logic [31:0] number, input logic typed,
                                input logic [87:0] text);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= number;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (typed)
        begin
            push_typed_text(text);
        end
        else
        begin
            push_decimal_text(number);
        end
        numbers_sent++;
        if (number[31])
        begin
            negatives_sent++;
        end
    endtask

    task automatic run_random(input int count, input int sender_pct, input int receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
        for (int i = 0; i < count; i++)
        begin
            offer_number(random_value(), 1'b0, 88'd0);
        end
    endtask

    // Output side: ready generation, the long hold-off and the character check.
    initial
    begin
        text_char_t want;
        int         held;
        out_ready     = 1'b0;
        hold_off_done = 1'b0;
        held          = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_text.size() == 0)
                begin
                    unexpected_beats++;
                    if (mismatches + unexpected_beats <= REPORT_LIMIT)
                    begin
                        $display("Unexpected beat: character %0d last %0b", character, last);
                    end
                end
                else
                begin
                    want = pending_text.pop_front();
                    chars_checked++;
                    if (character !== want.code || last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches + unexpected_beats <= REPORT_LIMIT)
                        begin
                            $display("Mismatch on beat %0d: character %0d expected %0d, last %0b expected %0b",
                                     chars_checked, character, want.code, last, want.last);
                        end
                    end
                end
            end
            if (hold_off_request && !hold_off_done)
            begin
                held++;
                if (held >= HOLD_OFF_CYCLES)
                begin
                    hold_off_done = 1'b1;
                end
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("Watchdog expired with %0d characters outstanding.", pending_text.size());
        $display("int32_to_decimal_ascii test failed");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        value              = 32'sd0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_request   = 1'b0;
        mismatches         = 0;
        unexpected_beats   = 0;
        numbers_sent       = 0;
        negatives_sent     = 0;
        chars_checked      = 0;

        add_row(32'd0,          1'b1, "0");
        add_row(32'h7FFF_FFFF,  1'b1, "2147483647");
        add_row(32'h8000_0000,  1'b1, "-2147483648");
        add_row(32'h8000_0001,  1'b1, "-2147483647");
        add_row(32'd1,          1'b1, "1");
        add_row(32'hFFFF_FFFF,  1'b1, "-1");
        add_row(32'd9,          1'b0, 88'd0);
        add_row(32'd10,         1'b0, 88'd0);
        add_row(-32'sd9,        1'b0, 88'd0);
        add_row(-32'sd10,       1'b0, 88'd0);
        add_row(32'd99,         1'b0, 88'd0);
        add_row(32'd100,        1'b0, 88'd0);
        add_row(32'd999999999,  1'b0, 88'd0);
        add_row(32'd1000000000, 1'b0, 88'd0);
        add_row(-32'sd999999999,  1'b0, 88'd0);
        add_row(-32'sd1000000000, 1'b0, 88'd0);
        add_row(32'd12345,      1'b0, 88'd0);
        add_row(32'h5555_5555,  1'b0, 88'd0);
        add_row(32'hAAAA_AAAA,  1'b0, 88'd0);
        add_row(32'h0001_0000,  1'b0, 88'd0);
        add_row(32'hFFFF_0000,  1'b0, 88'd0);
        add_row(32'd2000000000, 1'b0, 88'd0);
        add_row(32'd1999999999, 1'b0, 88'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            offer_number(directed_rows[i].number, directed_rows[i].typed,
                         directed_rows[i].text);
        end

        run_random(70, 0, 0);
        run_random(70, 57, 0);
        run_random(70, 0, 57);
        run_random(70, 26, 26);
        hold_off_request = 1'b1;
        run_random(20, 0, 0);
        run_random(50, 0, 0);

        in_valid <= 1'b0;
        while (pending_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d numbers (%0d negative) into %0d checked characters.",
                 numbers_sent, negatives_sent, chars_checked);
        $display("Idling covered none, sender only, receiver only, both, and a long hold-off.");
        if (mismatches == 0 && unexpected_beats == 0 && pending_text.size() == 0)
        begin
            $display("int32_to_decimal_ascii test passed");
        end
        else
        begin
            $display("%0d mismatches, %0d unexpected beats, %0d characters missing.",
                     mismatches, unexpected_beats, pending_text.size());
            $display("int32_to_decimal_ascii test failed");
        end
        $finish;
    end

endmodule
